@@ src/tshr_pkg.sv @@
// Shared types and constants for the time-slotted history ring.
// Holds the request and response transfer structs, the stored entry layout and status codes.
// No dependencies.
package tshr_pkg;

  localparam int unsigned SLOT_W  = 40;
  localparam int unsigned VALUE_W = 16;

  typedef enum logic [1:0] {
    STATUS_RECORDED = 2'd0,
    STATUS_STALE    = 2'd1,
    STATUS_HIT      = 2'd2,
    STATUS_MISS     = 2'd3
  } status_e;

  typedef enum logic {
    ACTION_RECORD = 1'b0,
    ACTION_READ   = 1'b1
  } action_e;

  typedef struct packed {
    action_e                    action;
    logic [SLOT_W-1:0]          slot;
    logic signed [VALUE_W-1:0]  air_tenths;
    logic                       air_ok;
    logic signed [VALUE_W-1:0]  skin_tenths;
    logic                       skin_ok;
    logic signed [VALUE_W-1:0]  hum_tenths;
    logic                       hum_ok;
  } req_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  air_out;
    logic                       air_valid;
    logic signed [VALUE_W-1:0]  skin_out;
    logic                       skin_valid;
    logic signed [VALUE_W-1:0]  hum_out;
    logic                       hum_valid;
  } rsp_t;

  // One ring entry, air in the low bits.
  typedef struct packed {
    logic                       hum_valid;
    logic signed [VALUE_W-1:0]  hum;
    logic                       skin_valid;
    logic signed [VALUE_W-1:0]  skin;
    logic                       air_valid;
    logic signed [VALUE_W-1:0]  air;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

@@ src/tshr_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters. No dependencies.
module tshr_ram #(
  parameter int unsigned WIDTH = 51,
  parameter int unsigned DEPTH = 1440
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/time_slotted_history_ring.sv @@
// Time-slotted history ring: top level with control sequencer and ring memory.
// Depends on tshr_pkg and tshr_ram.
// Sequence: a stale record ends in EVAL, a read miss in LOOKUP and a read hit in RDATA; a record
// runs EVAL, GAP, then FILL for each of N skipped slots (N capped at DEPTH) and the new entry.
// One item is in flight at a time; the gap fill writes one memory entry per cycle.
// Reset clears pointer, count, newest slot and sample flag; the ring memory needs no clearing.
module time_slotted_history_ring #(
  parameter int unsigned DEPTH = 1440
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  tshr_pkg::req_t  req_i,
  output logic            done_o,
  output tshr_pkg::rsp_t  rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = CW + 1;
  localparam int unsigned SW = tshr_pkg::SLOT_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_GAP    = 6'b000100,
    S_FILL   = 6'b001000,
    S_LOOKUP = 6'b010000,
    S_RDATA  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  tshr_pkg::req_t      req_q, req_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [CW-1:0]       count_q, count_d;
  logic [SW-1:0]       newest_q, newest_d;
  logic                has_q, has_d;
  logic [SW:0]         diff_q, diff_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic                done_q, done_d;
  tshr_pkg::rsp_t      rsp_q, rsp_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_raddr;
  tshr_pkg::entry_t    wentry, rentry;
  logic [tshr_pkg::ENTRY_W-1:0] ram_rdata;

  logic [SW:0]         rec_diff, rd_back;
  logic                stale;
  logic                hit;
  logic [IW-1:0]       idx_raw;
  logic [AW-1:0]       wp_inc;

  assign rec_diff = {1'b0, req_q.slot} - {1'b0, newest_q};
  assign rd_back  = {1'b0, newest_q} - {1'b0, req_q.slot};
  assign stale    = has_q && (rec_diff[SW] || (rec_diff == '0));

  // A borrow in the stored difference means the slot lies in the future.
  assign hit = has_q && !diff_q[SW] && (diff_q[SW-1:0] < SW'(count_q));

  // The newest entry sits just below the write pointer; step back from it.
  assign idx_raw = IW'(wp_q) + IW'(DEPTH - 1) - IW'(diff_q[CW-1:0]);

  assign wp_inc = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;

  always_comb begin
    wentry = '0;
    if (state_q == S_FILL && fill_q == '0) begin
      if (req_q.air_ok) begin
        wentry.air       = req_q.air_tenths;
        wentry.air_valid = 1'b1;
      end
      if (req_q.skin_ok) begin
        wentry.skin       = req_q.skin_tenths;
        wentry.skin_valid = 1'b1;
      end
      if (req_q.hum_ok) begin
        wentry.hum       = req_q.hum_tenths;
        wentry.hum_valid = 1'b1;
      end
    end
  end

  always_comb begin
    if (idx_raw >= IW'(DEPTH)) begin
      ram_raddr = AW'(idx_raw - IW'(DEPTH));
    end else begin
      ram_raddr = AW'(idx_raw);
    end
  end

  assign rentry = tshr_pkg::entry_t'(ram_rdata);

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    wp_d     = wp_q;
    count_d  = count_q;
    newest_d = newest_q;
    has_d    = has_q;
    diff_d   = diff_q;
    fill_d   = fill_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (req_q.action == tshr_pkg::ACTION_RECORD) begin
          diff_d = rec_diff;
          if (stale) begin
            done_d       = 1'b1;
            rsp_d        = '0;
            rsp_d.status = tshr_pkg::STATUS_STALE;
            state_d      = S_IDLE;
          end else begin
            state_d = S_GAP;
          end
        end else begin
          diff_d  = rd_back;
          state_d = S_LOOKUP;
        end
      end
      S_GAP: begin
        // Skipped slots number diff - 1, never more than the ring holds.
        if (!has_q) begin
          fill_d = '0;
        end else if (diff_q[SW-1:0] > SW'(DEPTH)) begin
          fill_d = CW'(DEPTH);
        end else begin
          fill_d = CW'(diff_q[SW-1:0] - 1'b1);
        end
        state_d = S_FILL;
      end
      S_FILL: begin
        ram_we = 1'b1;
        wp_d   = wp_inc;
        if (count_q < CW'(DEPTH)) begin
          count_d = count_q + 1'b1;
        end
        if (fill_q != '0) begin
          fill_d = fill_q - 1'b1;
        end else begin
          newest_d     = req_q.slot;
          has_d        = 1'b1;
          done_d       = 1'b1;
          rsp_d        = '0;
          rsp_d.status = tshr_pkg::STATUS_RECORDED;
          state_d      = S_IDLE;
        end
      end
      S_LOOKUP: begin
        if (hit) begin
          ram_re  = 1'b1;
          state_d = S_RDATA;
        end else begin
          done_d       = 1'b1;
          rsp_d        = '0;
          rsp_d.status = tshr_pkg::STATUS_MISS;
          state_d      = S_IDLE;
        end
      end
      S_RDATA: begin
        done_d           = 1'b1;
        rsp_d.status     = tshr_pkg::STATUS_HIT;
        rsp_d.air_out    = rentry.air;
        rsp_d.air_valid  = rentry.air_valid;
        rsp_d.skin_out   = rentry.skin;
        rsp_d.skin_valid = rentry.skin_valid;
        rsp_d.hum_out    = rentry.hum;
        rsp_d.hum_valid  = rentry.hum_valid;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wp_q     <= '0;
      count_q  <= '0;
      newest_q <= '0;
      has_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      count_q  <= count_d;
      newest_q <= newest_d;
      has_q    <= has_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    diff_q <= diff_d;
    fill_q <= fill_d;
    rsp_q  <= rsp_d;
  end

  tshr_ram #(
    .WIDTH (tshr_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (wentry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after a transfer was taken");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result strobe while an item is still in work");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above ring depth");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < AW'(DEPTH))
    else $error("write pointer outside the ring");

  a_read_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (state_q == S_RDATA) && !ram_we)
    else $error("ring read not followed by its data cycle");

endmodule

@@ verif/tshr_history_check.sv @@
// Checker for the time-slotted history ring: watches the request and response channels.
// Keeps its own copy of the ring to predict every response and compares them field by field.
// Depends on tshr_pkg.
`timescale 1ns / 100ps

module tshr_history_check #(
  parameter int unsigned DEPTH = 1440
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  tshr_pkg::req_t   req_i,
  input  logic             done_i,
  input  tshr_pkg::rsp_t   rsp_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o
);

  localparam int unsigned SHOWN_MAX = 10;
  localparam int unsigned SW        = tshr_pkg::SLOT_W;

  tshr_pkg::entry_t  ring [DEPTH];
  int unsigned       wr_ptr;
  int unsigned       held;
  logic [SW-1:0]     newest;
  logic              has_sample;
  tshr_pkg::rsp_t    pending_rsp [$];
  tshr_pkg::rsp_t    due_rsp;

  task automatic note_failure(input string msg);
    errors_o++;
    if (errors_o <= SHOWN_MAX) begin
      $display("history check @%0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  function automatic void push_entry(input tshr_pkg::entry_t e);
    ring[wr_ptr] = e;
    wr_ptr = (wr_ptr + 1) % DEPTH;
    if (held < DEPTH) held++;
  endfunction

  // Updates the local ring with one request and returns the response it must cause.
  function automatic tshr_pkg::rsp_t predict_response(input tshr_pkg::req_t r);
    tshr_pkg::rsp_t    rsp;
    tshr_pkg::entry_t  e;
    logic [SW-1:0]     fill;
    int unsigned       idx;
    rsp = '0;
    e   = '0;
    if (r.action == tshr_pkg::ACTION_RECORD) begin
      if (has_sample && r.slot <= newest) begin
        rsp.status = tshr_pkg::STATUS_STALE;
      end else begin
        if (has_sample) begin
          fill = r.slot - newest - 1;
          if (fill > DEPTH) fill = SW'(DEPTH);
          for (int unsigned k = 0; k < int'(fill); k++) push_entry('0);
        end
        if (r.air_ok) begin
          e.air       = r.air_tenths;
          e.air_valid = 1'b1;
        end
        if (r.skin_ok) begin
          e.skin       = r.skin_tenths;
          e.skin_valid = 1'b1;
        end
        if (r.hum_ok) begin
          e.hum       = r.hum_tenths;
          e.hum_valid = 1'b1;
        end
        push_entry(e);
        newest     = r.slot;
        has_sample = 1'b1;
        rsp.status = tshr_pkg::STATUS_RECORDED;
      end
    end else if (!has_sample || r.slot > newest || (newest - r.slot) >= held) begin
      rsp.status = tshr_pkg::STATUS_MISS;
    end else begin
      idx = (wr_ptr + 2 * DEPTH - 1 - int'(newest - r.slot)) % DEPTH;
      e   = ring[idx];
      rsp.status     = tshr_pkg::STATUS_HIT;
      rsp.air_out    = e.air;
      rsp.air_valid  = e.air_valid;
      rsp.skin_out   = e.skin;
      rsp.skin_valid = e.skin_valid;
      rsp.hum_out    = e.hum;
      rsp.hum_valid  = e.hum_valid;
    end
    return rsp;
  endfunction

  // A response can leave in the same cycle as the next request is taken, so compare first, then predict.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr     = 0;
      held       = 0;
      newest     = '0;
      has_sample = 1'b0;
      pending_rsp.delete();
      errors_o   = 0;
      pending_o  = 0;
    end else begin
      if (done_i === 1'b1) begin
        if (pending_rsp.size() == 0) begin
          note_failure("response with no request waiting for one");
        end else begin
          due_rsp = pending_rsp.pop_front();
          check_field("status", due_rsp.status, rsp_i.status);
          check_field("air_out", due_rsp.air_out, rsp_i.air_out);
          check_field("air_valid", due_rsp.air_valid, rsp_i.air_valid);
          check_field("skin_out", due_rsp.skin_out, rsp_i.skin_out);
          check_field("skin_valid", due_rsp.skin_valid, rsp_i.skin_valid);
          check_field("hum_out", due_rsp.hum_out, rsp_i.hum_out);
          check_field("hum_valid", due_rsp.hum_valid, rsp_i.hum_valid);
        end
      end else if (done_i !== 1'b0) begin
        note_failure("done strobe is unknown");
      end
      if (start_i && busy_i === 1'b0) begin
        pending_rsp.push_back(predict_response(req_i));
      end
      pending_o = pending_rsp.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Top of the testbench for the time-slotted history ring: clock, reset and request stimulus.
// Instantiates time_slotted_history_ring and tshr_history_check; uses tshr_pkg.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SW           = tshr_pkg::SLOT_W;
  localparam int unsigned VW           = tshr_pkg::VALUE_W;
  localparam int unsigned DEPTH        = 1440;
  localparam int unsigned RANDOM_ITEMS = 630;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned SETTLE       = 12;
  localparam logic [SW-1:0] SLOT_TOP   = '1;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  tshr_pkg::req_t  req;
  logic            done;
  tshr_pkg::rsp_t  rsp;
  int unsigned     errors;
  int unsigned     pending;
  int unsigned     cycle_count;

  // What has been sent so far, used only to aim the stimulus at the held window.
  logic [SW-1:0]     newest_sent;
  int unsigned       held_sent;
  logic              recorded;
  logic              idle_on;

  time_slotted_history_ring #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  tshr_history_check #(
    .DEPTH (DEPTH)
  ) i_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_i    (busy),
    .req_i     (req),
    .done_i    (done),
    .rsp_i     (rsp),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic signed [VW-1:0] pick_reading();
    logic signed [VW-1:0] v;
    case ($urandom_range(9))
      0:       v = 16'sh7fff;
      1:       v = 16'sh8000;
      2:       v = -16'sd1;
      default: v = VW'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [SW-1:0] rand_slot();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[SW-1:0];
  endfunction

  function automatic tshr_pkg::req_t make_req(input tshr_pkg::action_e act,
                                              input logic [SW-1:0] s);
    tshr_pkg::req_t r;
    r.action      = act;
    r.slot        = s;
    r.air_tenths  = pick_reading();
    r.air_ok      = ($urandom_range(9) < 8);
    r.skin_tenths = pick_reading();
    r.skin_ok     = ($urandom_range(9) < 8);
    r.hum_tenths  = pick_reading();
    r.hum_ok      = ($urandom_range(9) < 8);
    return r;
  endfunction

  function automatic tshr_pkg::req_t make_record(input logic [SW-1:0] s,
                                       input logic signed [VW-1:0] a, input logic a_ok,
                                       input logic signed [VW-1:0] k, input logic k_ok,
                                       input logic signed [VW-1:0] h, input logic h_ok);
    tshr_pkg::req_t r;
    r = '{tshr_pkg::ACTION_RECORD, s, a, a_ok, k, k_ok, h, h_ok};
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(input tshr_pkg::req_t r);
    logic [SW-1:0] fill;
    if (idle_on) begin
      while ($urandom_range(99) < 11) begin
        start = 1'b0;
        req   = make_req(tshr_pkg::action_e'($urandom_range(1)), rand_slot());
        @(negedge clk_i);
      end
    end
    if (r.action == tshr_pkg::ACTION_RECORD && (!recorded || r.slot > newest_sent)) begin
      if (recorded) begin
        fill = r.slot - newest_sent - 1;
        if (fill > DEPTH) fill = SW'(DEPTH);
        held_sent = held_sent + int'(fill) + 1;
        if (held_sent > DEPTH) held_sent = DEPTH;
      end else begin
        held_sent = 1;
      end
      newest_sent = r.slot;
      recorded    = 1'b1;
    end
    req   = r;
    start = 1'b1;
    // busy only moves at rising edges, so the value seen here holds at the next one.
    while (busy !== 1'b0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [SW-1:0]     s;
    logic [63:0]       wide;
    int unsigned       pick;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req         = '0;
    cycle_count = 0;
    newest_sent = '0;
    held_sent   = 0;
    recorded    = 1'b0;
    idle_on     = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reads before any record, then first record, stale records, small gaps and reads across them.
    send(make_req(tshr_pkg::ACTION_READ, '0));
    send(make_req(tshr_pkg::ACTION_READ, SLOT_TOP));
    send(make_record(40'd100, 16'sh7fff, 1'b1, 16'sh8000, 1'b1, 16'sh1234, 1'b0));
    send(make_record(40'd100, 16'sd5, 1'b1, 16'sd5, 1'b1, 16'sd5, 1'b1));
    send(make_record(40'd50, 16'sd7, 1'b1, 16'sd7, 1'b1, 16'sd7, 1'b1));
    send(make_record(40'd101, -16'sd1, 1'b1, 16'sd1, 1'b0, 16'sh7fff, 1'b1));
    send(make_record(40'd105, 16'sh8000, 1'b1, 16'sh7fff, 1'b1, 16'sh8000, 1'b1));
    send(make_req(tshr_pkg::ACTION_READ, 40'd105));
    send(make_req(tshr_pkg::ACTION_READ, 40'd103));
    send(make_req(tshr_pkg::ACTION_READ, 40'd101));
    send(make_req(tshr_pkg::ACTION_READ, 40'd100));
    send(make_req(tshr_pkg::ACTION_READ, 40'd99));
    send(make_req(tshr_pkg::ACTION_READ, 40'd106));
    // A gap of exactly DEPTH slots fills the whole ring.
    send(make_record(40'd105 + DEPTH + 1, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0));
    send(make_req(tshr_pkg::ACTION_READ, newest_sent));
    send(make_req(tshr_pkg::ACTION_READ, newest_sent - (DEPTH - 1)));
    send(make_req(tshr_pkg::ACTION_READ, newest_sent - DEPTH));
    // Longer gap than the ring: fill is capped.
    send(make_record(newest_sent + 2000, 16'sd250, 1'b1, 16'sd360, 1'b1, 16'sd555, 1'b1));
    send(make_req(tshr_pkg::ACTION_READ, newest_sent - 1));

    idle_on = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 300 && n < 450);
      pick    = $urandom_range(999);
      wide    = {$urandom(), $urandom()};
      if (pick < 470) begin
        if (pick < 330) begin
          s = newest_sent + 1;
        end else if (pick < 400) begin
          s = newest_sent + $urandom_range(20, 2);
        end else if (pick < 445) begin
          s = newest_sent - $urandom_range(3, 0);
        end else if (pick < 460) begin
          s = newest_sent + $urandom_range(DEPTH + 3, DEPTH - 1);
        end else begin
          s = newest_sent + wide[31:0];
        end
        send(make_req(tshr_pkg::ACTION_RECORD, s));
      end else begin
        if (pick < 650) begin
          s = newest_sent - $urandom_range(5, 0);
        end else if (pick < 820) begin
          s = newest_sent - $urandom_range(held_sent, 0);
        end else if (pick < 900) begin
          case ($urandom_range(2))
            0:       s = newest_sent - held_sent;
            1:       s = newest_sent - held_sent + 1;
            default: s = newest_sent + 1;
          endcase
        end else begin
          s = wide[SW-1:0];
        end
        send(make_req(tshr_pkg::ACTION_READ, s));
      end
    end

    // The top slot closes the run, since every later record would be stale.
    idle_on = 1'b0;
    send(make_record(SLOT_TOP, 16'sh7fff, 1'b1, 16'sh8000, 1'b1, -16'sd1, 1'b1));
    send(make_req(tshr_pkg::ACTION_READ, SLOT_TOP));
    send(make_req(tshr_pkg::ACTION_READ, SLOT_TOP - 1));
    send(make_record(SLOT_TOP, 16'sd1, 1'b1, 16'sd1, 1'b1, 16'sd1, 1'b1));
    send(make_req(tshr_pkg::ACTION_READ, '0));

    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
